### rtl/servo_slew_rate_limiter_defines.svh
// ---------------------------------------------------------------------------
// Servo slew rate limiter assertion macros
// Shared assertion wrappers for the servo slew rate limiter.
// ---------------------------------------------------------------------------
`ifndef SERVO_SLEW_RATE_LIMITER_DEFINES_SVH
`define SERVO_SLEW_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SSRL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSRL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ssrl_pkg.sv
// ---------------------------------------------------------------------------
// Servo slew rate limiter package
// Constants, codes and types shared by the servo slew rate limiter files.
// ---------------------------------------------------------------------------
`default_nettype none

package ssrl_pkg;

  localparam int NUM_SERVOS   = 3;
  localparam int CENTER_PULSE = 1500;
  localparam int DEFAULT_STEP = 50;

  localparam int PULSE_W   = 16;
  localparam int ID_W      = 2;
  localparam int VAL_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;

  localparam logic [PULSE_W-1:0] PULSE_FLOOR_RST   = PULSE_W'(500);
  localparam logic [PULSE_W-1:0] PULSE_CEIL_RST    = PULSE_W'(2500);
  localparam logic [PULSE_W-1:0] UPDATE_PERIOD_RST = PULSE_W'(20);

  typedef enum logic [1:0] {
    REQ_TARGET = 2'd0,
    REQ_SPEED  = 2'd1,
    REQ_STOP   = 2'd2,
    REQ_TICK   = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_FLOOR   = 2'd0,
    CFG_PULSE_CEIL    = 2'd1,
    CFG_UPDATE_PERIOD = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_REQ,
    S_PASS_RD,
    S_PASS_WR
  } state_t;

  typedef struct packed {
    logic [PULSE_W-1:0] current;
    logic [PULSE_W-1:0] target;
    logic [PULSE_W-1:0] step;
  } servo_entry_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    servo_entry_t       wr_data;
  } mem_cmd_t;

  localparam servo_entry_t RESET_ENTRY = '{
    current: PULSE_W'(CENTER_PULSE),
    target:  PULSE_W'(CENTER_PULSE),
    step:    PULSE_W'(DEFAULT_STEP)
  };

endpackage

`default_nettype wire

### rtl/ssrl_req_if.sv
// ---------------------------------------------------------------------------
// Servo request channel
// Valid/ready channel carrying one request to the servo slew rate limiter.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssrl_req_if;
  logic                               valid;
  logic                               ready;
  ssrl_pkg::req_type_t                req_type;
  logic [ssrl_pkg::ID_W-1:0]          servo_sel;
  logic signed [ssrl_pkg::VAL_W-1:0]  value;

  modport source (output valid, output req_type, output servo_sel, output value,
                  input ready);
  modport sink   (input valid, input req_type, input servo_sel, input value,
                  output ready);
endinterface

`default_nettype wire

### rtl/ssrl_res_if.sv
// ---------------------------------------------------------------------------
// Servo result channel
// Valid/ready channel carrying one result from the servo slew rate limiter.
// ---------------------------------------------------------------------------
`default_nettype none

interface ssrl_res_if;
  logic                          valid;
  logic                          ready;
  logic [ssrl_pkg::ID_W-1:0]     out_servo;
  logic [ssrl_pkg::PULSE_W-1:0]  pulse_us;
  logic                          moving;
  logic                          drive_update;
  logic                          is_last;

  modport source (output valid, output out_servo, output pulse_us,
                  output moving, output drive_update, output is_last,
                  input ready);
  modport sink   (input valid, input out_servo, input pulse_us,
                  input moving, input drive_update, input is_last,
                  output ready);
endinterface

`default_nettype wire

### rtl/ssrl_state_mem.sv
// ---------------------------------------------------------------------------
// Servo state memory
// One-port-read, one-port-write synchronous store of per-servo pulse state,
// with registered read data and per-entry valid bits for the reset value.
// ---------------------------------------------------------------------------
`default_nettype none

module ssrl_state_mem (
  input  logic                   clk,
  input  logic                   rst,
  input  ssrl_pkg::mem_cmd_t     cmd,
  output ssrl_pkg::servo_entry_t rd_entry
);

  ssrl_pkg::servo_entry_t          mem [ssrl_pkg::NUM_SERVOS];
  logic [ssrl_pkg::NUM_SERVOS-1:0] vld;
  ssrl_pkg::servo_entry_t          rd_q;
  logic                            rd_vld;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_vld <= vld[cmd.rd_addr];
      end
      if (cmd.wr_en) begin
        vld[cmd.wr_addr] <= 1'b1;
      end
    end
  end

  // An entry never written since reset reads as the reset state.
  assign rd_entry = rd_vld ? rd_q : ssrl_pkg::RESET_ENTRY;

endmodule

`default_nettype wire

### rtl/ssrl_step_calc.sv
// ---------------------------------------------------------------------------
// Servo state update
// Computes the new state of one servo for a request or an update pass step.
// ---------------------------------------------------------------------------
`default_nettype none

module ssrl_step_calc (
  input  ssrl_pkg::req_type_t               op,
  input  ssrl_pkg::servo_entry_t            entry_in,
  input  logic                              moving_in,
  input  logic signed [ssrl_pkg::VAL_W-1:0] value,
  input  logic [ssrl_pkg::PULSE_W-1:0]      pulse_floor,
  input  logic [ssrl_pkg::PULSE_W-1:0]      pulse_ceil,
  output ssrl_pkg::servo_entry_t            entry_out,
  output logic                              moving_out
);

  logic signed [ssrl_pkg::VAL_W-1:0] diff;
  logic [ssrl_pkg::VAL_W-1:0]        mag;
  logic                              snap;

  assign diff = $signed({1'b0, entry_in.target}) - $signed({1'b0, entry_in.current});
  assign mag  = diff[ssrl_pkg::VAL_W-1] ? ssrl_pkg::VAL_W'(-diff) : ssrl_pkg::VAL_W'(diff);
  assign snap = (mag <= {1'b0, entry_in.step});

  always_comb begin
    entry_out  = entry_in;
    moving_out = moving_in;
    unique case (op)
      ssrl_pkg::REQ_TARGET: begin
        if (value < $signed({1'b0, pulse_floor})) begin
          entry_out.target = pulse_floor;
        end else if (value > $signed({1'b0, pulse_ceil})) begin
          entry_out.target = pulse_ceil;
        end else begin
          entry_out.target = value[ssrl_pkg::PULSE_W-1:0];
        end
        moving_out = 1'b1;
      end
      ssrl_pkg::REQ_SPEED: begin
        entry_out.step = value[ssrl_pkg::VAL_W-1] ? '0 : value[ssrl_pkg::PULSE_W-1:0];
      end
      ssrl_pkg::REQ_STOP: begin
        entry_out.target = entry_in.current;
        moving_out       = 1'b0;
      end
      ssrl_pkg::REQ_TICK: begin
        if (snap) begin
          entry_out.current = entry_in.target;
          moving_out        = 1'b0;
        end else if (!diff[ssrl_pkg::VAL_W-1]) begin
          entry_out.current = entry_in.current + entry_in.step;
        end else begin
          entry_out.current = entry_in.current - entry_in.step;
        end
      end
      default: begin
        entry_out  = entry_in;
        moving_out = moving_in;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/servo_slew_rate_limiter.sv
// A set-target, set-speed or stop request first reads its servo entry from the state memory, then in S_REQ,
// once the result register is free, writes the entry back and loads the result; ready is raised only in S_IDLE.
// A tick that runs an update pass walks the servos in order, reading and writing back each moving servo.
// A tick that runs no pass gives no result.
// Synchronous reset restores the registers, clears moving flags and the tick count,
// and marks every servo entry as holding the centre pulse and default step.
// ---------------------------------------------------------------------------
// Servo slew rate limiter
// Per-servo pulse ramp held in a state memory, with a sequencer that serves
// status requests and walks the servos on every update pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "servo_slew_rate_limiter_defines.svh"

module servo_slew_rate_limiter (
  input  logic                                 clk,
  input  logic                                 rst,
  ssrl_req_if.sink                             req,
  ssrl_res_if.source                           res,
  input  logic                                 cfg_we,
  input  logic [ssrl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ssrl_pkg::PULSE_W-1:0]         cfg_data
);

  localparam logic [ssrl_pkg::IDX_W-1:0] IDX_LAST = ssrl_pkg::IDX_W'(ssrl_pkg::NUM_SERVOS - 1);

  ssrl_pkg::state_t                     state, state_next;
  logic [ssrl_pkg::IDX_W-1:0]           idx, idx_next;
  logic [ssrl_pkg::NUM_SERVOS-1:0]      mov, mov_next;
  logic [ssrl_pkg::PULSE_W-1:0]         elapsed, elapsed_next, elapsed_inc;
  logic [ssrl_pkg::PULSE_W-1:0]         pulse_floor, pulse_ceil, update_period;

  ssrl_pkg::req_type_t                  rq_type;
  logic [ssrl_pkg::ID_W-1:0]            rq_id;
  logic [ssrl_pkg::IDX_W-1:0]           rq_addr;
  logic                                 rq_ok;
  logic signed [ssrl_pkg::VAL_W-1:0]    rq_val;
  logic                                 rq_load;
  logic                                 in_ok;

  logic                                 out_vld, out_free, out_load;
  logic [ssrl_pkg::ID_W-1:0]            out_servo, out_servo_next;
  logic [ssrl_pkg::PULSE_W-1:0]         out_pulse, out_pulse_next;
  logic                                 out_mov, out_mov_next;
  logic                                 out_drive, out_drive_next;
  logic                                 out_last, out_last_next;

  ssrl_pkg::mem_cmd_t                   mem_cmd;
  ssrl_pkg::servo_entry_t               rd_entry, new_entry;
  ssrl_pkg::req_type_t                  calc_op;
  logic [ssrl_pkg::IDX_W-1:0]           cur_addr;
  logic                                 new_mov;
  logic                                 later;
  logic                                 wb_state;
  logic                                 pass_wr;

  ssrl_state_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .cmd      (mem_cmd),
    .rd_entry (rd_entry)
  );

  assign calc_op  = (state == ssrl_pkg::S_PASS_WR) ? ssrl_pkg::REQ_TICK : rq_type;
  assign cur_addr = (state == ssrl_pkg::S_PASS_WR) ? idx : rq_addr;

  ssrl_step_calc u_calc (
    .op          (calc_op),
    .entry_in    (rd_entry),
    .moving_in   (mov[cur_addr]),
    .value       (rq_val),
    .pulse_floor (pulse_floor),
    .pulse_ceil  (pulse_ceil),
    .entry_out   (new_entry),
    .moving_out  (new_mov)
  );

  assign in_ok       = (req.servo_sel != '0) && (int'(req.servo_sel) <= ssrl_pkg::NUM_SERVOS);
  assign elapsed_inc = (elapsed == '1) ? elapsed : elapsed + 1'b1;
  assign out_free    = !out_vld || res.ready;
  assign wb_state    = (state == ssrl_pkg::S_REQ) || (state == ssrl_pkg::S_PASS_WR);
  assign pass_wr     = (state == ssrl_pkg::S_PASS_WR) && mem_cmd.wr_en;

  always_comb begin
    later = 1'b0;
    for (int j = 0; j < ssrl_pkg::NUM_SERVOS; j++) begin
      if ((j > int'(idx)) && mov[j]) begin
        later = 1'b1;
      end
    end
  end

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    mov_next       = mov;
    elapsed_next   = elapsed;
    rq_load        = 1'b0;
    out_load       = 1'b0;
    out_servo_next = '0;
    out_pulse_next = '0;
    out_mov_next   = 1'b0;
    out_drive_next = 1'b0;
    out_last_next  = 1'b1;
    mem_cmd        = '0;
    req.ready      = 1'b0;
    unique case (state)
      ssrl_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          rq_load = 1'b1;
          if (req.req_type == ssrl_pkg::REQ_TICK) begin
            if (elapsed_inc >= update_period) begin
              elapsed_next = '0;
              if (|mov) begin
                idx_next   = '0;
                state_next = ssrl_pkg::S_PASS_RD;
              end
            end else begin
              elapsed_next = elapsed_inc;
            end
          end else begin
            state_next      = ssrl_pkg::S_REQ;
            mem_cmd.rd_en   = in_ok;
            mem_cmd.rd_addr = ssrl_pkg::IDX_W'(req.servo_sel - 1'b1);
          end
        end
      end
      ssrl_pkg::S_REQ: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ssrl_pkg::S_IDLE;
          if (rq_ok) begin
            mem_cmd.wr_en     = 1'b1;
            mem_cmd.wr_addr   = rq_addr;
            mem_cmd.wr_data   = new_entry;
            mov_next[rq_addr] = new_mov;
            out_servo_next    = rq_id;
            out_pulse_next    = new_entry.current;
            out_mov_next      = new_mov;
          end
        end
      end
      ssrl_pkg::S_PASS_RD: begin
        if (mov[idx]) begin
          mem_cmd.rd_en   = 1'b1;
          mem_cmd.rd_addr = idx;
          state_next      = ssrl_pkg::S_PASS_WR;
        end else if (idx == IDX_LAST) begin
          state_next = ssrl_pkg::S_IDLE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ssrl_pkg::S_PASS_WR: begin
        if (out_free) begin
          mem_cmd.wr_en   = 1'b1;
          mem_cmd.wr_addr = idx;
          mem_cmd.wr_data = new_entry;
          mov_next[idx]   = new_mov;
          out_load        = 1'b1;
          out_servo_next  = ssrl_pkg::ID_W'(idx) + 1'b1;
          out_pulse_next  = new_entry.current;
          out_mov_next    = new_mov;
          out_drive_next  = 1'b1;
          out_last_next   = !later;
          if (idx == IDX_LAST) begin
            state_next = ssrl_pkg::S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = ssrl_pkg::S_PASS_RD;
          end
        end
      end
      default: begin
        state_next = ssrl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ssrl_pkg::S_IDLE;
      idx     <= '0;
      mov     <= '0;
      elapsed <= '0;
      out_vld <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      mov     <= mov_next;
      elapsed <= elapsed_next;
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (res.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_floor   <= ssrl_pkg::PULSE_FLOOR_RST;
      pulse_ceil    <= ssrl_pkg::PULSE_CEIL_RST;
      update_period <= ssrl_pkg::UPDATE_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssrl_pkg::CFG_PULSE_FLOOR:   pulse_floor   <= cfg_data;
        ssrl_pkg::CFG_PULSE_CEIL:    pulse_ceil    <= cfg_data;
        ssrl_pkg::CFG_UPDATE_PERIOD: update_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rq_load) begin
      rq_type <= req.req_type;
      rq_id   <= req.servo_sel;
      rq_addr <= ssrl_pkg::IDX_W'(req.servo_sel - 1'b1);
      rq_ok   <= in_ok;
      rq_val  <= req.value;
    end
    if (out_load) begin
      out_servo <= out_servo_next;
      out_pulse <= out_pulse_next;
      out_mov   <= out_mov_next;
      out_drive <= out_drive_next;
      out_last  <= out_last_next;
    end
  end

  assign res.valid        = out_vld;
  assign res.out_servo    = out_servo;
  assign res.pulse_us     = out_pulse;
  assign res.moving       = out_mov;
  assign res.drive_update = out_drive;
  assign res.is_last      = out_last;

  `SSRL_ASSERT_NOW(a_wr_in_rmw, clk, rst, mem_cmd.wr_en, wb_state, "write outside write-back")
  `SSRL_ASSERT_NOW(a_pass_moving, clk, rst, pass_wr, mov[idx], "pass wrote a servo at rest")
  `SSRL_ASSERT_NEXT(a_load_sets_valid, clk, rst, out_load, out_vld, "loaded result not presented")

endmodule

`default_nettype wire

### tb/servo_slew_rate_limiter_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Servo slew rate limiter testbench
// Drives status requests and millisecond ticks into the block, predicts each
// servo's pulse ramp and compares every result in order. A table of directed
// requests and register writes comes first, then random phases under several
// limit and period settings, with bursty requests and a stalling receiver.
// ---------------------------------------------------------------------------
module servo_slew_rate_limiter_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_PHASES = 7;
  localparam int PH_LO [NUM_PHASES] = '{500, 0, 1000, 65535, -1, 300, 0};
  localparam int PH_HI [NUM_PHASES] = '{2500, 65535, 2000, 0, -1, 3000, 65535};
  localparam int PH_PER [NUM_PHASES] = '{20, 1, 3, 2, -1, 65535, 0};
  localparam int PH_CNT [NUM_PHASES] = '{10, 16, 14, 8, 14, 8, 8};
  localparam int PRESSURE_PHASE = 1;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_pattern_t;

  typedef struct packed {
    logic [ssrl_pkg::ID_W-1:0]    servo;
    logic [ssrl_pkg::PULSE_W-1:0] pulse;
    logic                         moving;
    logic                         drive;
    logic                         last;
  } pulse_res_t;

  typedef struct {
    bit                                 is_cfg;
    ssrl_pkg::cfg_reg_t                 cfg_sel;
    logic [ssrl_pkg::PULSE_W-1:0]       cfg_val;
    ssrl_pkg::req_type_t                rt;
    logic [ssrl_pkg::ID_W-1:0]          id;
    logic signed [ssrl_pkg::VAL_W-1:0]  val;
    bit                                 typed;
    pulse_res_t                         want;
  } stim_row_t;

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           cfg_we;
  logic [ssrl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ssrl_pkg::PULSE_W-1:0]   cfg_data;

  ssrl_req_if req();
  ssrl_res_if res();

  servo_slew_rate_limiter dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [ssrl_pkg::PULSE_W-1:0] pw_now  [1:ssrl_pkg::NUM_SERVOS];
  logic [ssrl_pkg::PULSE_W-1:0] pw_goal [1:ssrl_pkg::NUM_SERVOS];
  logic [ssrl_pkg::PULSE_W-1:0] pw_step [1:ssrl_pkg::NUM_SERVOS];
  logic                         travelling [1:ssrl_pkg::NUM_SERVOS];
  logic [ssrl_pkg::PULSE_W-1:0] tick_count;
  logic [ssrl_pkg::PULSE_W-1:0] lim_lo;
  logic [ssrl_pkg::PULSE_W-1:0] lim_hi;
  logic [ssrl_pkg::PULSE_W-1:0] period_cfg;

  pulse_res_t pulses_due [$];
  int         errors = 0;
  int         burst_left = 0;
  bit         no_gaps = 1'b0;
  logic       hold_ask = 1'b0;

  task automatic note_mismatch(input string msg);
    $display("%0t ns: %s", $realtime, msg);
    errors++;
  endtask

  // Applies one accepted request to the servo state and queues the results it causes.
  function automatic void servo_ramp_step(input ssrl_pkg::req_type_t rt,
                                          input logic [ssrl_pkg::ID_W-1:0] id,
                                          input logic signed [ssrl_pkg::VAL_W-1:0] v);
    pulse_res_t pass_out [ssrl_pkg::NUM_SERVOS];
    int n;
    int cnt;
    int per;
    int goal;
    int now;
    int stp;
    int diff;
    int mag;
    int t;
    int lo;
    int hi;
    n = 0;
    lo = int'(lim_lo);
    hi = int'(lim_hi);
    if (rt == ssrl_pkg::REQ_TICK) begin
      if (tick_count != 16'hFFFF) tick_count++;
      cnt = int'(tick_count);
      per = int'(period_cfg);
      if (cnt >= per) begin
        tick_count = '0;
        for (int i = 1; i <= ssrl_pkg::NUM_SERVOS; i++) begin
          if (travelling[i]) begin
            goal = int'(pw_goal[i]);
            now = int'(pw_now[i]);
            stp = int'(pw_step[i]);
            diff = goal - now;
            mag = (diff < 0) ? -diff : diff;
            if (mag <= stp) begin
              pw_now[i] = pw_goal[i];
              travelling[i] = 1'b0;
            end else if (diff > 0) begin
              pw_now[i] = pw_now[i] + pw_step[i];
            end else begin
              pw_now[i] = pw_now[i] - pw_step[i];
            end
            pass_out[n] = '{servo: ssrl_pkg::ID_W'(i), pulse: pw_now[i],
                            moving: travelling[i], drive: 1'b1, last: 1'b0};
            n++;
          end
        end
        if (n > 0) pass_out[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) pulses_due.push_back(pass_out[k]);
      end
    end else if (id < 1 || id > ssrl_pkg::NUM_SERVOS) begin
      pulses_due.push_back('{servo: '0, pulse: '0, moving: 1'b0, drive: 1'b0, last: 1'b1});
    end else begin
      case (rt)
        ssrl_pkg::REQ_TARGET: begin
          t = int'(v);
          if (t < lo) t = lo;
          else if (t > hi) t = hi;
          pw_goal[id] = ssrl_pkg::PULSE_W'(t);
          travelling[id] = 1'b1;
        end
        ssrl_pkg::REQ_SPEED: begin
          t = int'(v);
          if (t < 0) t = 0;
          pw_step[id] = ssrl_pkg::PULSE_W'(t);
        end
        default: begin
          pw_goal[id] = pw_now[id];
          travelling[id] = 1'b0;
        end
      endcase
      pulses_due.push_back('{servo: id, pulse: pw_now[id], moving: travelling[id],
                             drive: 1'b0, last: 1'b1});
    end
  endfunction

  function automatic stim_row_t req_row(input ssrl_pkg::req_type_t rt, input int id,
                                        input int v);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_sel = ssrl_pkg::CFG_PULSE_FLOOR;
    r.cfg_val = '0;
    r.rt = rt;
    r.id = ssrl_pkg::ID_W'(id);
    r.val = ssrl_pkg::VAL_W'(v);
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t chk_row(input ssrl_pkg::req_type_t rt, input int id,
                                        input int v, input int servo, input int pulse,
                                        input bit mov);
    stim_row_t r;
    r = req_row(rt, id, v);
    r.typed = 1'b1;
    r.want = '{servo: ssrl_pkg::ID_W'(servo), pulse: ssrl_pkg::PULSE_W'(pulse),
               moving: mov, drive: 1'b0, last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input ssrl_pkg::cfg_reg_t sel, input int d);
    stim_row_t r;
    r = req_row(ssrl_pkg::REQ_TICK, 0, 0);
    r.is_cfg = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = ssrl_pkg::PULSE_W'(d);
    return r;
  endfunction

  task automatic send_request(input ssrl_pkg::req_type_t rt,
                              input logic [ssrl_pkg::ID_W-1:0] id,
                              input logic signed [ssrl_pkg::VAL_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req.valid     <= 1'b1;
    req.req_type  <= rt;
    req.servo_sel <= id;
    req.value     <= v;
    do @(posedge clk); while (req.ready !== 1'b1);
    servo_ramp_step(rt, id, v);
    burst_left--;
  endtask

  // A tick that causes no result may still be in flight, so the task keeps waiting after the queue drains.
  task automatic settle_idle();
    req.valid <= 1'b0;
    while (pulses_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input ssrl_pkg::cfg_reg_t sel,
                           input logic [ssrl_pkg::PULSE_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= d;
    @(posedge clk);
    case (sel)
      ssrl_pkg::CFG_PULSE_FLOOR: lim_lo = d;
      ssrl_pkg::CFG_PULSE_CEIL:  lim_hi = d;
      default:                   period_cfg = d;
    endcase
  endtask

  initial begin
    rx_pattern_t rx_mode;
    int          rx_left;
    int          hold_left;
    bit          held;
    pulse_res_t  want;
    rx_mode = RX_OPEN;
    rx_left = 0;
    hold_left = 0;
    held = 1'b0;
    res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && res.valid === 1'b1 && res.ready === 1'b1) begin
        if (pulses_due.size() == 0) begin
          note_mismatch($sformatf("result for servo %0d with nothing expected", res.out_servo));
        end else begin
          want = pulses_due.pop_front();
          if (res.out_servo !== want.servo)
            note_mismatch($sformatf("out_servo: got %0d, expected %0d",
                                    res.out_servo, want.servo));
          if (res.pulse_us !== want.pulse)
            note_mismatch($sformatf("pulse_us: got %0d, expected %0d",
                                    res.pulse_us, want.pulse));
          if (res.moving !== want.moving)
            note_mismatch($sformatf("moving: got %0b, expected %0b", res.moving, want.moving));
          if (res.drive_update !== want.drive)
            note_mismatch($sformatf("drive_update: got %0b, expected %0b",
                                    res.drive_update, want.drive));
          if (res.is_last !== want.last)
            note_mismatch($sformatf("is_last: got %0b, expected %0b", res.is_last, want.last));
        end
      end
      if (hold_ask && !held) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (rx_left == 0) begin
        rx_mode = rx_pattern_t'($urandom_range(0, 2));
        rx_left = $urandom_range(8, 48);
      end
      rx_left--;
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   res.ready <= 1'b1;
          RX_RANDOM: res.ready <= ($urandom_range(0, 3) != 0);
          default:   res.ready <= (rx_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("servo_slew_rate_limiter_test: FAIL");
    $finish;
  end

  initial begin
    stim_row_t                         rows [$];
    ssrl_pkg::req_type_t               rt;
    logic [ssrl_pkg::ID_W-1:0]         id;
    logic signed [ssrl_pkg::VAL_W-1:0] v;
    int                                lo;
    int                                hi;
    int                                per;
    int                                sel;
    int                                pick;
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= ssrl_pkg::CFG_PULSE_FLOOR;
    cfg_data  <= '0;
    req.valid     <= 1'b0;
    req.req_type  <= ssrl_pkg::REQ_TICK;
    req.servo_sel <= '0;
    req.value     <= '0;
    for (int i = 1; i <= ssrl_pkg::NUM_SERVOS; i++) begin
      pw_now[i] = ssrl_pkg::PULSE_W'(ssrl_pkg::CENTER_PULSE);
      pw_goal[i] = ssrl_pkg::PULSE_W'(ssrl_pkg::CENTER_PULSE);
      pw_step[i] = ssrl_pkg::PULSE_W'(ssrl_pkg::DEFAULT_STEP);
      travelling[i] = 1'b0;
    end
    tick_count = '0;
    lim_lo = ssrl_pkg::PULSE_FLOOR_RST;
    lim_hi = ssrl_pkg::PULSE_CEIL_RST;
    period_cfg = ssrl_pkg::UPDATE_PERIOD_RST;

    rows.push_back(chk_row(ssrl_pkg::REQ_SPEED, 1, 50, 1, ssrl_pkg::CENTER_PULSE, 1'b0));
    rows.push_back(chk_row(ssrl_pkg::REQ_SPEED, 0, 7, 0, 0, 1'b0));
    rows.push_back(chk_row(ssrl_pkg::REQ_TARGET, 1, -65536, 1, ssrl_pkg::CENTER_PULSE, 1'b1));
    rows.push_back(chk_row(ssrl_pkg::REQ_TARGET, 2, 65535, 2, ssrl_pkg::CENTER_PULSE, 1'b1));
    rows.push_back(chk_row(ssrl_pkg::REQ_TARGET, 3, ssrl_pkg::CENTER_PULSE, 3,
                           ssrl_pkg::CENTER_PULSE, 1'b1));
    rows.push_back(chk_row(ssrl_pkg::REQ_SPEED, 3, -1, 3, ssrl_pkg::CENTER_PULSE, 1'b1));
    rows.push_back(chk_row(ssrl_pkg::REQ_SPEED, 2, 65535, 2, ssrl_pkg::CENTER_PULSE, 1'b1));
    rows.push_back(chk_row(ssrl_pkg::REQ_STOP, 0, 0, 0, 0, 1'b0));
    rows.push_back(req_row(ssrl_pkg::REQ_TICK, 3, -1));
    rows.push_back(cfg_row(ssrl_pkg::CFG_UPDATE_PERIOD, 0));
    rows.push_back(req_row(ssrl_pkg::REQ_TICK, 0, 65535));
    rows.push_back(req_row(ssrl_pkg::REQ_SPEED, 1, 0));
    rows.push_back(req_row(ssrl_pkg::REQ_TICK, 1, 0));
    rows.push_back(req_row(ssrl_pkg::REQ_STOP, 1, 0));
    rows.push_back(cfg_row(ssrl_pkg::CFG_PULSE_FLOOR, 3000));
    rows.push_back(cfg_row(ssrl_pkg::CFG_PULSE_CEIL, 1000));
    rows.push_back(req_row(ssrl_pkg::REQ_TARGET, 2, 2000));
    rows.push_back(req_row(ssrl_pkg::REQ_TARGET, 3, 65535));
    rows.push_back(cfg_row(ssrl_pkg::CFG_PULSE_FLOOR, 0));
    rows.push_back(cfg_row(ssrl_pkg::CFG_PULSE_CEIL, 65535));
    rows.push_back(req_row(ssrl_pkg::REQ_TARGET, 1, 0));
    rows.push_back(req_row(ssrl_pkg::REQ_TARGET, 1, 65535));
    rows.push_back(req_row(ssrl_pkg::REQ_SPEED, 1, 65535));
    rows.push_back(req_row(ssrl_pkg::REQ_TICK, 2, -65536));
    rows.push_back(req_row(ssrl_pkg::REQ_STOP, 3, 0));
    rows.push_back(req_row(ssrl_pkg::REQ_TICK, 2, -65536));
    rows.push_back(req_row(ssrl_pkg::REQ_STOP, 2, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        settle_idle();
        write_reg(rows[k].cfg_sel, rows[k].cfg_val);
        cfg_we <= 1'b0;
      end else begin
        send_request(rows[k].rt, rows[k].id, rows[k].val);
        if (rows[k].typed) begin
          void'(pulses_due.pop_back());
          pulses_due.push_back(rows[k].want);
        end
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      lo = (PH_LO[p] < 0) ? $urandom_range(0, 2000) : PH_LO[p];
      hi = (PH_HI[p] < 0) ? $urandom_range(1000, 4000) : PH_HI[p];
      per = (PH_PER[p] < 0) ? $urandom_range(1, 4) : PH_PER[p];
      write_reg(ssrl_pkg::CFG_PULSE_FLOOR, ssrl_pkg::PULSE_W'(lo));
      write_reg(ssrl_pkg::CFG_PULSE_CEIL, ssrl_pkg::PULSE_W'(hi));
      write_reg(ssrl_pkg::CFG_UPDATE_PERIOD, ssrl_pkg::PULSE_W'(per));
      cfg_we <= 1'b0;
      no_gaps = (p == PRESSURE_PHASE);
      if (p == PRESSURE_PHASE) hold_ask <= 1'b1;
      repeat (PH_CNT[p]) begin
        sel = $urandom_range(0, 99);
        if (sel < 40) rt = ssrl_pkg::REQ_TICK;
        else if (sel < 70) rt = ssrl_pkg::REQ_TARGET;
        else if (sel < 85) rt = ssrl_pkg::REQ_SPEED;
        else rt = ssrl_pkg::REQ_STOP;
        id = ($urandom_range(0, 9) == 0) ? '0 :
             ssrl_pkg::ID_W'($urandom_range(1, ssrl_pkg::NUM_SERVOS));
        pick = $urandom_range(0, 9);
        case (rt)
          ssrl_pkg::REQ_TARGET: begin
            if (pick == 0) v = ssrl_pkg::VAL_W'($urandom);
            else if (pick == 1) v = ssrl_pkg::VAL_W'(-1);
            else v = ssrl_pkg::VAL_W'($urandom_range(0, 3200));
          end
          ssrl_pkg::REQ_SPEED: begin
            if (pick == 0) v = ssrl_pkg::VAL_W'($urandom);
            else if (pick == 1) v = ssrl_pkg::VAL_W'(-int'($urandom_range(1, 100)));
            else v = ssrl_pkg::VAL_W'($urandom_range(0, 400));
          end
          default: v = ssrl_pkg::VAL_W'($urandom);
        endcase
        send_request(rt, id, v);
      end
    end

    settle_idle();
    if (errors == 0) begin
      $display("servo_slew_rate_limiter_test: PASS");
    end else begin
      $display("servo_slew_rate_limiter_test: FAIL");
    end
    $finish;
  end

endmodule
